// File: rtl/vtwd_pkg.sv
// package for the vertex transform with perspective divide core
// holds fixed-point constants, register indexes and transaction structs
`timescale 1ns / 1ps
package vtwd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_BITS = 32 + FRAC_BITS;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int SUM_W = 66 - FRAC_BITS;
  localparam int LATENCY = DIV_STAGES + 4;

  localparam logic signed [31:0] ONE_FX = 32'(64'sd1 <<< FRAC_BITS);

  // operating modes
  localparam logic [1:0] MODE_XFORM_DIV = 2'd0;
  localparam logic [1:0] MODE_DIV_ONLY = 2'd1;
  localparam logic [1:0] MODE_DIR = 2'd2;
  localparam logic [1:0] MODE_XFORM = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_ROW0_XY = 3'd0;
  localparam logic [2:0] REG_ROW1_XY = 3'd1;
  localparam logic [2:0] REG_ROW2_XY = 3'd2;
  localparam logic [2:0] REG_ROW3_XY = 3'd3;
  localparam logic [2:0] REG_COL2_ROWS01 = 3'd4;
  localparam logic [2:0] REG_COL2_ROWS23 = 3'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic use_z_as_w;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_w;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic zero_divisor;
    logic saturated;
  } out_t;

  // sideband that rides along the divider pipeline
  typedef struct packed {
    logic div_en;
    logic zdiv;
    logic sat;
    logic [2:0][31:0] r;
    logic [31:0] w;
  } side_t;

  // divider lane state for the three components
  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][DIV_BITS-1:0] num;
    logic [2:0] neg;
    logic [31:0] den;
  } div_t;

endpackage

// File: rtl/vertex_transform_w_divide_core.sv
// vertex transform with perspective divide, top level
// depends on vtwd_pkg for constants and transaction structs
`timescale 1ns / 1ps
// Accepts one vector transaction per clock whenever start is high; busy is
// always low. Each result appears on result for one cycle with done high,
// in input order. The pipeline is built around the restoring divider: two
// quotient bits per stage over 32 + FRAC_BITS quotient bits, behind one
// multiply stage, one sum/saturate stage and one divisor-select stage, plus
// the output register. Matrix registers may only be written while no
// transaction is in flight.
module vertex_transform_w_divide_core (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  vtwd_pkg::in_t in_item,
  output logic done,
  output vtwd_pkg::out_t result,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] row0_xy, row1_xy, row2_xy, row3_xy, col2_rows01, col2_rows23;
  logic signed [31:0] mat [4][3];

  // pipeline never stalls
  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row0_xy <= 64'(vtwd_pkg::ONE_FX);
      row1_xy <= {vtwd_pkg::ONE_FX, 32'd0};
      row2_xy <= '0;
      row3_xy <= '0;
      col2_rows01 <= '0;
      col2_rows23 <= 64'(vtwd_pkg::ONE_FX);
    end else if (cfg_we) begin
      case (cfg_index)
        vtwd_pkg::REG_ROW0_XY: row0_xy <= cfg_data;
        vtwd_pkg::REG_ROW1_XY: row1_xy <= cfg_data;
        vtwd_pkg::REG_ROW2_XY: row2_xy <= cfg_data;
        vtwd_pkg::REG_ROW3_XY: row3_xy <= cfg_data;
        vtwd_pkg::REG_COL2_ROWS01: col2_rows01 <= cfg_data;
        vtwd_pkg::REG_COL2_ROWS23: col2_rows23 <= cfg_data;
        default: ;
      endcase
    end
  end

  // matrix element view
  always_comb begin
    mat[0][0] = row0_xy[31:0];
    mat[0][1] = row0_xy[63:32];
    mat[0][2] = col2_rows01[31:0];
    mat[1][0] = row1_xy[31:0];
    mat[1][1] = row1_xy[63:32];
    mat[1][2] = col2_rows01[63:32];
    mat[2][0] = row2_xy[31:0];
    mat[2][1] = row2_xy[63:32];
    mat[2][2] = col2_rows23[31:0];
    mat[3][0] = row3_xy[31:0];
    mat[3][1] = row3_xy[63:32];
    mat[3][2] = col2_rows23[63:32];
  end

  // stage 1: nine products
  logic s1_valid;
  vtwd_pkg::in_t s1_in;
  logic signed [63:0] s1_prod [3][3];
  logic signed [31:0] s1_trans [3];
  logic signed [31:0] vin [3];

  assign vin[0] = in_item.pos_x;
  assign vin[1] = in_item.pos_y;
  assign vin[2] = in_item.pos_z;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= start;
  end

  always_ff @(posedge clk) begin
    s1_in <= in_item;
    for (int c = 0; c < 3; c++) begin
      s1_trans[c] <= (in_item.mode == vtwd_pkg::MODE_DIR) ? 32'sd0 : mat[3][c];
      for (int r = 0; r < 3; r++) begin
        s1_prod[r][c] <= 64'(vin[r]) * 64'(mat[r][c]);
      end
    end
  end

  // stage 2: floored sums and saturation, or the raw input in div-only mode
  logic s2_valid;
  vtwd_pkg::in_t s2_in;
  logic [2:0][31:0] s2_r;
  logic s2_sat;
  logic [2:0][31:0] sum_sat;
  logic [2:0] sum_clamp;
  logic signed [vtwd_pkg::SUM_W-1:0] sum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = vtwd_pkg::SUM_W'(s1_prod[0][c] >>> vtwd_pkg::FRAC_BITS)
             + vtwd_pkg::SUM_W'(s1_prod[1][c] >>> vtwd_pkg::FRAC_BITS)
             + vtwd_pkg::SUM_W'(s1_prod[2][c] >>> vtwd_pkg::FRAC_BITS)
             + vtwd_pkg::SUM_W'(s1_trans[c]);
      sum_clamp[c] = !((&sum[c][vtwd_pkg::SUM_W-1:31]) || !(|sum[c][vtwd_pkg::SUM_W-1:31]));
      if (sum_clamp[c]) sum_sat[c] = sum[c][vtwd_pkg::SUM_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      else sum_sat[c] = sum[c][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_in <= s1_in;
    if (s1_in.mode == vtwd_pkg::MODE_DIV_ONLY) begin
      s2_r <= {s1_in.pos_z, s1_in.pos_y, s1_in.pos_x};
      s2_sat <= 1'b0;
    end else begin
      s2_r <= sum_sat;
      s2_sat <= |sum_clamp;
    end
  end

  // stage 3: divisor select and divider setup
  logic dv_valid [vtwd_pkg::DIV_STAGES+1];
  vtwd_pkg::div_t dv [vtwd_pkg::DIV_STAGES+1];
  vtwd_pkg::side_t sd [vtwd_pkg::DIV_STAGES+1];
  logic [31:0] den_sel;
  logic div_mode;
  vtwd_pkg::div_t dv0;
  vtwd_pkg::side_t sd0;
  logic [31:0] amag;

  always_comb begin
    div_mode = (s2_in.mode == vtwd_pkg::MODE_XFORM_DIV) ||
               (s2_in.mode == vtwd_pkg::MODE_DIV_ONLY);
    den_sel = s2_in.use_z_as_w ? s2_r[2] : s2_in.pos_w;
    sd0.div_en = div_mode;
    sd0.zdiv = div_mode && (den_sel == 32'd0);
    sd0.sat = s2_sat;
    sd0.r = s2_r;
    case (s2_in.mode)
      vtwd_pkg::MODE_DIR: sd0.w = 32'd0;
      vtwd_pkg::MODE_XFORM: sd0.w = s2_in.use_z_as_w ? s2_r[2] : vtwd_pkg::ONE_FX;
      default: sd0.w = vtwd_pkg::ONE_FX;
    endcase
    dv0.den = den_sel[31] ? (32'd0 - den_sel) : den_sel;
    amag = '0;
    for (int c = 0; c < 3; c++) begin
      amag = s2_r[c][31] ? (32'd0 - s2_r[c]) : s2_r[c];
      dv0.rem[c] = '0;
      dv0.num[c] = {amag, vtwd_pkg::FRAC_BITS'(0)};
      dv0.neg[c] = s2_r[c][31] ^ den_sel[31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else dv_valid[0] <= s2_valid;
  end

  always_ff @(posedge clk) begin
    dv[0] <= dv0;
    sd[0] <= sd0;
  end

  // restoring divider, DIV_STEPS quotient bits per stage
  for (genvar k = 0; k < vtwd_pkg::DIV_STAGES; k++) begin : g_div
    vtwd_pkg::div_t nx;
    logic [32:0] t;

    always_comb begin
      nx = dv[k];
      t = '0;
      for (int j = 0; j < vtwd_pkg::DIV_STEPS; j++) begin
        if (k * vtwd_pkg::DIV_STEPS + j < vtwd_pkg::DIV_BITS) begin
          for (int c = 0; c < 3; c++) begin
            t = {nx.rem[c], nx.num[c][vtwd_pkg::DIV_BITS-1]};
            if (t >= {1'b0, nx.den}) begin
              nx.rem[c] = 32'(t - {1'b0, nx.den});
              nx.num[c] = {nx.num[c][vtwd_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
              nx.rem[c] = t[31:0];
              nx.num[c] = {nx.num[c][vtwd_pkg::DIV_BITS-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_valid[k+1] <= 1'b0;
      else dv_valid[k+1] <= dv_valid[k];
    end

    always_ff @(posedge clk) begin
      dv[k+1] <= nx;
      sd[k+1] <= sd[k];
    end
  end

  // output stage: sign, saturation and mode select
  localparam logic [vtwd_pkg::DIV_BITS-1:0] MIN_MAG = vtwd_pkg::DIV_BITS'(64'd1 << 31);
  vtwd_pkg::div_t dl;
  vtwd_pkg::side_t sl;
  vtwd_pkg::out_t res_next;
  logic [2:0][31:0] q;
  logic [2:0] qclamp;
  logic mag_fits;

  assign dl = dv[vtwd_pkg::DIV_STAGES];
  assign sl = sd[vtwd_pkg::DIV_STAGES];

  always_comb begin
    mag_fits = 1'b0;
    for (int c = 0; c < 3; c++) begin
      mag_fits = !(|dl.num[c][vtwd_pkg::DIV_BITS-1:31]);
      if (dl.neg[c]) begin
        qclamp[c] = !(mag_fits || (dl.num[c] == MIN_MAG));
        q[c] = qclamp[c] ? 32'h8000_0000 : (32'd0 - dl.num[c][31:0]);
      end else begin
        qclamp[c] = !mag_fits;
        q[c] = qclamp[c] ? 32'h7fff_ffff : dl.num[c][31:0];
      end
    end
    res_next.zero_divisor = sl.zdiv;
    if (!sl.div_en) begin
      res_next.out_x = sl.r[0];
      res_next.out_y = sl.r[1];
      res_next.out_z = sl.r[2];
      res_next.out_w = sl.w;
      res_next.saturated = sl.sat;
    end else if (sl.zdiv) begin
      res_next.out_x = '0;
      res_next.out_y = '0;
      res_next.out_z = '0;
      res_next.out_w = '0;
      res_next.saturated = sl.sat;
    end else begin
      res_next.out_x = q[0];
      res_next.out_y = q[1];
      res_next.out_z = q[2];
      res_next.out_w = vtwd_pkg::ONE_FX;
      res_next.saturated = sl.sat || (|qclamp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv_valid[vtwd_pkg::DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

`ifndef SYNTH
  // every accepted transaction comes out with done at the end of the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(vtwd_pkg::LATENCY) done)
    else $error("result missing after pipeline latency");

  // no result without a transaction in the pipe
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, vtwd_pkg::LATENCY))
    else $error("result without matching transaction");

  // zero divisor clears the vector (checked on out_x and out_w)
  a_zdiv_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_divisor) |->
      (result.out_x == 32'd0 && result.out_w == 32'd0))
    else $error("zero divisor result not cleared");
`endif

endmodule
